[hdl/sjf_pkg.sv]
package sjf_pkg;

  localparam int MAX_JOBS    = 32;
  localparam int TIME_BITS   = 16;
  localparam int CLK_W       = 22;
  localparam int TOT_W       = 28;
  localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int CMP_W       = (TIME_BITS > CLK_W) ? TIME_BITS : CLK_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] tval_t;
  typedef logic [CLK_W-1:0]     clk_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [CMP_W:0]       wide_t;
  typedef logic [TOT_W-1:0]     tot_t;
  typedef logic [TOT_W:0]       tot_wide_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [Q_PTR_W-1:0]   qptr_t;
  typedef logic [Q_CNT_W-1:0]   qcnt_t;

  localparam clk_t  CLK_MAX = '1;
  localparam tot_t  TOT_MAX = '1;
  localparam qcnt_t Q_FULL  = qcnt_t'(QUEUE_DEPTH);

  typedef struct packed {
    idx_t  idx;
    clk_t  start;
    clk_t  fin;
    tval_t arrival;
    tval_t burst;
    logic  last;
  } dispatch_t;

endpackage

[hdl/sjf_if.sv]
interface sjf_job_if;
  logic        valid;
  logic        ready;
  logic [15:0] arrive_at;
  logic [15:0] run_length;
  logic        last_job;

  modport source (output valid, arrive_at, run_length, last_job, input ready);
  modport sink (input valid, arrive_at, run_length, last_job, output ready);
endinterface

interface sjf_result_if;
  logic        valid;
  logic        ready;
  logic [5:0]  job_index;
  logic [21:0] start_at;
  logic [21:0] finish_at;
  logic [21:0] turnaround;
  logic [21:0] waiting;
  logic [27:0] total_turnaround;
  logic [27:0] total_waiting;
  logic        last_result;

  modport source (output valid, job_index, start_at, finish_at, turnaround, waiting,
                  total_turnaround, total_waiting, last_result, input ready);
  modport sink (input valid, job_index, start_at, finish_at, turnaround, waiting,
                total_turnaround, total_waiting, last_result, output ready);
endinterface

[hdl/sjf_nonpreemptive_scheduler_top.sv]
// Non-preemptive shortest-job-first scheduler.
// The jobs channel loads one job per transaction: arrival time, burst time and
// a last-job mark. Up to MAX_JOBS jobs of a set are held and
// further jobs of the same set are dropped. The transaction that carries the
// last-job mark starts scheduling, and the jobs channel stays not ready until
// every result of the set has been handed to the result queue.
// Each dispatch scans all n held jobs through the single read port of the job
// memory, one job per cycle, and then picks one. Each result passes through
// the result queue, a stage register and the output register to the results channel.
// One result transaction per job comes out in dispatch order, with start,
// finish, turnaround and waiting times and the running totals of the set.
// A four-entry queue and an output register decouple the scan from the
// results channel: when the receiver stalls, the scan runs on until the queue
// fills and then waits, and no result is lost.
// Synchronous reset empties the job set, the queue and the output register.
module sjf_nonpreemptive_scheduler_top (
  input  logic         clk,
  input  logic         rst,
  sjf_job_if.sink      jobs,
  sjf_result_if.source results
);

  logic               push_valid;
  logic               push_ready;
  sjf_pkg::dispatch_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  sjf_pkg::dispatch_t pop_data;

  sjf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .jobs       (jobs),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  sjf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  sjf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

[hdl/sjf_front.sv]
module sjf_front (
  input  logic               clk,
  input  logic               rst,
  sjf_job_if.sink            jobs,
  output logic               push_valid,
  output sjf_pkg::dispatch_t push_data,
  input  logic               push_ready
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  function automatic sjf_pkg::clk_t sat_clk(sjf_pkg::wide_t v);
    return (v > sjf_pkg::wide_t'(sjf_pkg::CLK_MAX)) ? sjf_pkg::CLK_MAX : sjf_pkg::clk_t'(v);
  endfunction

  logic [1:0]                    state;
  sjf_pkg::cnt_t                 count;
  sjf_pkg::cnt_t                 dispatched;
  sjf_pkg::cnt_t                 scan_addr;
  sjf_pkg::clk_t                 clock_now;
  logic [sjf_pkg::MAX_JOBS-1:0]  done_flags;

  sjf_pkg::tval_t arr_mem [sjf_pkg::MAX_JOBS];
  sjf_pkg::tval_t bur_mem [sjf_pkg::MAX_JOBS];

  logic           rd_valid;
  sjf_pkg::idx_t  rd_idx;
  sjf_pkg::tval_t rd_arr;
  sjf_pkg::tval_t rd_bur;
  logic           rd_done;

  logic           ready_found;
  sjf_pkg::idx_t  r_idx;
  sjf_pkg::tval_t r_arr;
  sjf_pkg::tval_t r_bur;
  logic           pend_found;
  sjf_pkg::idx_t  p_idx;
  sjf_pkg::tval_t p_arr;
  sjf_pkg::tval_t p_bur;

  logic           load_fire;
  logic           store_en;
  logic           issue;
  logic           eval;
  logic           is_ready;
  logic           take_ready;
  logic           take_pend;
  logic           push_fire;
  logic           last_pick;
  sjf_pkg::idx_t  sel_idx;
  sjf_pkg::tval_t sel_arr;
  sjf_pkg::tval_t sel_bur;
  sjf_pkg::clk_t  start_at;
  sjf_pkg::clk_t  finish_at;

  assign jobs.ready = (state == ST_LOAD);
  assign load_fire  = jobs.valid && jobs.ready;
  assign store_en   = load_fire && (count < sjf_pkg::cnt_t'(sjf_pkg::MAX_JOBS));
  assign issue      = (state == ST_SCAN) && (scan_addr < count);
  assign eval       = rd_valid && !rd_done;
  assign is_ready   = sjf_pkg::cmp_t'(rd_arr) <= sjf_pkg::cmp_t'(clock_now);

  assign take_ready = eval && is_ready &&
                      (!ready_found || (rd_bur < r_bur) ||
                       ((rd_bur == r_bur) && (rd_arr < r_arr)));
  assign take_pend  = eval &&
                      (!pend_found || (rd_arr < p_arr) ||
                       ((rd_arr == p_arr) && (rd_bur < p_bur)));

  // With nothing ready the clock jumps to the earliest pending arrival.
  assign sel_idx   = ready_found ? r_idx : p_idx;
  assign sel_arr   = ready_found ? r_arr : p_arr;
  assign sel_bur   = ready_found ? r_bur : p_bur;
  assign start_at  = ready_found ? clock_now : sat_clk(sjf_pkg::wide_t'(p_arr));
  assign finish_at = sat_clk(sjf_pkg::wide_t'(start_at) + sjf_pkg::wide_t'(sel_bur));

  assign push_valid = (state == ST_DECIDE);
  assign push_fire  = push_valid && push_ready;
  assign last_pick  = (dispatched + sjf_pkg::cnt_t'(1)) == count;

  always_comb begin
    push_data.idx     = sel_idx;
    push_data.start   = start_at;
    push_data.fin     = finish_at;
    push_data.arrival = sel_arr;
    push_data.burst   = sel_bur;
    push_data.last    = last_pick;
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      arr_mem[count[sjf_pkg::IDX_W-1:0]] <= sjf_pkg::tval_t'(jobs.arrive_at);
      bur_mem[count[sjf_pkg::IDX_W-1:0]] <= sjf_pkg::tval_t'(jobs.run_length);
    end
    if (issue) begin
      rd_arr  <= arr_mem[scan_addr[sjf_pkg::IDX_W-1:0]];
      rd_bur  <= bur_mem[scan_addr[sjf_pkg::IDX_W-1:0]];
      rd_idx  <= scan_addr[sjf_pkg::IDX_W-1:0];
      rd_done <= done_flags[scan_addr[sjf_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready) begin
      r_idx <= rd_idx;
      r_arr <= rd_arr;
      r_bur <= rd_bur;
    end
    if (take_pend) begin
      p_idx <= rd_idx;
      p_arr <= rd_arr;
      p_bur <= rd_bur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      count       <= '0;
      dispatched  <= '0;
      scan_addr   <= '0;
      clock_now   <= '0;
      done_flags  <= '0;
      rd_valid    <= 1'b0;
      ready_found <= 1'b0;
      pend_found  <= 1'b0;
    end else begin
      rd_valid <= issue;
      unique case (state)
        ST_LOAD: begin
          if (load_fire) begin
            if (store_en) begin
              count <= count + sjf_pkg::cnt_t'(1);
            end
            if (jobs.last_job) begin
              state       <= ST_SCAN;
              scan_addr   <= '0;
              dispatched  <= '0;
              ready_found <= 1'b0;
              pend_found  <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + sjf_pkg::cnt_t'(1);
          end
          if (take_ready) begin
            ready_found <= 1'b1;
          end
          if (take_pend) begin
            pend_found <= 1'b1;
          end
          if (!issue && !rd_valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (push_ready) begin
            if (last_pick) begin
              state      <= ST_LOAD;
              count      <= '0;
              dispatched <= '0;
              clock_now  <= '0;
              done_flags <= '0;
            end else begin
              done_flags[sel_idx] <= 1'b1;
              clock_now           <= finish_at;
              dispatched          <= dispatched + sjf_pkg::cnt_t'(1);
              state               <= ST_SCAN;
              scan_addr           <= '0;
              ready_found         <= 1'b0;
              pend_found          <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pick_not_done: assert property (@(posedge clk) disable iff (rst)
    push_fire |-> !done_flags[sel_idx])
    else $error("dispatched a job that already finished");

  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_data.fin >= push_data.start))
    else $error("finish time before start time");

  a_clock_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ((clock_now == '0) && (done_flags == '0)))
    else $error("schedule state not cleared while loading");
`endif

endmodule

[hdl/sjf_queue.sv]
module sjf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  sjf_pkg::dispatch_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  output sjf_pkg::dispatch_t pop_data,
  input  logic               pop_ready
);

  sjf_pkg::dispatch_t entries [sjf_pkg::QUEUE_DEPTH];
  sjf_pkg::qptr_t     wr_ptr;
  sjf_pkg::qptr_t     rd_ptr;
  sjf_pkg::qcnt_t     fill;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (fill != sjf_pkg::Q_FULL);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + sjf_pkg::qptr_t'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + sjf_pkg::qptr_t'(1);
      end
      if (push_fire && !pop_fire) begin
        fill <= fill + sjf_pkg::qcnt_t'(1);
      end else if (pop_fire && !push_fire) begin
        fill <= fill - sjf_pkg::qcnt_t'(1);
      end
    end
  end

endmodule

[hdl/sjf_back.sv]
module sjf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  sjf_pkg::dispatch_t pop_data,
  output logic               pop_ready,
  sjf_result_if.source       results
);

  function automatic sjf_pkg::tot_t sat_tot(sjf_pkg::tot_wide_t v);
    return (v > sjf_pkg::tot_wide_t'(sjf_pkg::TOT_MAX)) ? sjf_pkg::TOT_MAX
                                                          : sjf_pkg::tot_t'(v);
  endfunction

  logic          a_valid;
  sjf_pkg::idx_t a_idx;
  sjf_pkg::clk_t a_start;
  sjf_pkg::clk_t a_fin;
  sjf_pkg::clk_t a_ta;
  sjf_pkg::clk_t a_wt;
  logic          a_last;

  sjf_pkg::tot_t sum_ta;
  sjf_pkg::tot_t sum_wt;
  logic          out_valid;

  logic          take_a;
  logic          pop_fire;
  sjf_pkg::cmp_t fin_ext;
  sjf_pkg::cmp_t arr_ext;
  sjf_pkg::cmp_t bur_ext;
  sjf_pkg::cmp_t ta_ext;
  sjf_pkg::clk_t ta_calc;
  sjf_pkg::clk_t wt_calc;
  sjf_pkg::tot_t tot_ta;
  sjf_pkg::tot_t tot_wt;

  assign take_a    = !out_valid || results.ready;
  assign pop_ready = !a_valid || take_a;
  assign pop_fire  = pop_valid && pop_ready;

  // The finish time is already saturated, so turnaround fits the clock width.
  assign fin_ext = sjf_pkg::cmp_t'(pop_data.fin);
  assign arr_ext = sjf_pkg::cmp_t'(pop_data.arrival);
  assign bur_ext = sjf_pkg::cmp_t'(pop_data.burst);
  assign ta_calc = (fin_ext > arr_ext) ? sjf_pkg::clk_t'(fin_ext - arr_ext) : '0;
  assign ta_ext  = sjf_pkg::cmp_t'(ta_calc);
  assign wt_calc = (ta_ext > bur_ext) ? sjf_pkg::clk_t'(ta_ext - bur_ext) : '0;

  assign tot_ta = sat_tot(sjf_pkg::tot_wide_t'(sum_ta) + sjf_pkg::tot_wide_t'(a_ta));
  assign tot_wt = sat_tot(sjf_pkg::tot_wide_t'(sum_wt) + sjf_pkg::tot_wide_t'(a_wt));

  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      a_idx   <= pop_data.idx;
      a_start <= pop_data.start;
      a_fin   <= pop_data.fin;
      a_ta    <= ta_calc;
      a_wt    <= wt_calc;
      a_last  <= pop_data.last;
    end
    if (a_valid && take_a) begin
      results.job_index        <= 6'(a_idx);
      results.start_at         <= a_start;
      results.finish_at        <= a_fin;
      results.turnaround       <= a_ta;
      results.waiting          <= a_wt;
      results.total_turnaround <= tot_ta;
      results.total_waiting    <= tot_wt;
      results.last_result      <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      sum_ta    <= '0;
      sum_wt    <= '0;
    end else begin
      if (pop_fire) begin
        a_valid <= 1'b1;
      end else if (take_a) begin
        a_valid <= 1'b0;
      end
      if (a_valid && take_a) begin
        out_valid <= 1'b1;
        sum_ta    <= a_last ? '0 : tot_ta;
        sum_wt    <= a_last ? '0 : tot_wt;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_totals_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (results.total_waiting <= results.total_turnaround))
    else $error("total waiting exceeds total turnaround");

  a_wait_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (results.waiting <= results.turnaround))
    else $error("waiting exceeds turnaround");

  a_ta_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (results.turnaround <= results.finish_at))
    else $error("turnaround exceeds finish time");
`endif

endmodule
